FILE: hdl/nfsa_pkg.sv
package nfsa_pkg;

    localparam int NFSA_SLOTS = 256;

    localparam int OWNER_W    = 32;
    localparam int SLOT_IN_W  = 9;
    localparam int SLOT_OUT_W = 8;
    localparam int SCAN_W     = 16;

    localparam logic [OWNER_W-1:0] OWNER_NONE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_LOOKUP   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_OBJECT  = 3'd1,
        ST_ALREADY    = 3'd2,
        ST_MEM_ERROR  = 3'd3,
        ST_FULL       = 3'd4,
        ST_BAD_SLOT   = 3'd5
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load_in;      // input transfer: latch item, read owner memory
        logic finish_read;  // resolve lookup / release / refused register
        logic scan_init;    // start free-slot scan at next-fit pointer
        logic scan_step;    // advance scan to next word
        logic claim;        // take the slot found in the current word
        logic finish_full;  // scan wrapped with no free slot
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic reg_go;       // latched op is register and all object flags pass
        logic scan_hit;     // current scan word has a free slot
        logic scan_last;    // current scan word is the final visit
    } t_stat;

endpackage

FILE: hdl/nfsa_ctrl.sv
module nfsa_ctrl
    import nfsa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                if (i_stat.reg_go) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.finish_read = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    o_cmd.claim = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_DONE;
                end else if (i_stat.scan_last) begin
                    o_cmd.finish_full = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/nfsa_dp.sv
module nfsa_dp
    import nfsa_pkg::*;
#(
    parameter int SLOTS = NFSA_SLOTS
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [1:0]            i_operation,
    input  logic                  i_object_present,
    input  logic                  i_object_registered,
    input  logic                  i_object_memory_error,
    input  logic [OWNER_W-1:0]    i_owner_in,
    input  logic [SLOT_IN_W-1:0]  i_slot_index,
    output logic [2:0]            o_status,
    output logic [SLOT_OUT_W-1:0] o_slot_out,
    output logic [OWNER_W-1:0]    o_owner_out,
    output logic                  o_slot_was_used
);

    localparam int PW  = $clog2(SLOTS);
    localparam int G   = (SLOTS + SCAN_W - 1) / SCAN_W;   // scan words
    localparam int GW  = (G > 1) ? $clog2(G) : 1;
    localparam int AW  = GW + $clog2(SCAN_W);
    localparam int CW  = $clog2(G + 1);
    localparam int OW  = $clog2(SCAN_W);

    // state
    logic [SLOTS-1:0]   r_used;
    logic [OWNER_W-1:0] r_owner_mem [SLOTS];
    logic [PW-1:0]      r_ptr;

    // latched item
    logic [1:0]           r_op;
    logic                 r_present, r_registered, r_memerr;
    logic [OWNER_W-1:0]   r_owner_in;
    logic [SLOT_IN_W-1:0] r_slot_idx;
    logic [OWNER_W-1:0]   r_rd_data;

    // scan
    logic [GW-1:0] r_grp;
    logic [OW-1:0] r_ofs;
    logic          r_first;
    logic [CW-1:0] r_cnt;

    // result
    logic [2:0]            r_status;
    logic [SLOT_OUT_W-1:0] r_slot_out;
    logic [OWNER_W-1:0]    r_owner_out;
    logic                  r_was_used;

    logic [SCAN_W-1:0] w_free_words [G];
    logic [SCAN_W-1:0] w_word;
    logic [SCAN_W-1:0] w_mask;
    logic [OW-1:0]     w_hit_bit;
    logic [PW-1:0]     w_claim_idx;
    logic [PW-1:0]     w_next_ptr;
    logic [PW-1:0]     w_rd_addr;
    logic [PW-1:0]     w_idx;
    logic              w_in_range;
    logic              w_idx_used;

    // free map, padded with "used" past the last slot
    for (genvar g = 0; g < G; g++) begin : g_word
        for (genvar b = 0; b < SCAN_W; b++) begin : g_bit
            if (g * SCAN_W + b < SLOTS) begin : g_real
                assign w_free_words[g][b] = ~r_used[g * SCAN_W + b];
            end else begin : g_pad
                assign w_free_words[g][b] = 1'b0;
            end
        end
    end

    assign w_mask = r_first ? ({SCAN_W{1'b1}} << r_ofs) : {SCAN_W{1'b1}};
    assign w_word = w_free_words[r_grp] & w_mask;

    // lowest free bit of the word
    always_comb begin
        w_hit_bit = '0;
        for (int k = SCAN_W - 1; k >= 0; k--) begin
            if (w_word[k]) begin
                w_hit_bit = OW'(k);
            end
        end
    end

    assign w_claim_idx = PW'({r_grp, w_hit_bit});
    assign w_next_ptr  = (w_claim_idx == PW'(SLOTS - 1)) ? '0 : w_claim_idx + 1'b1;

    assign o_stat.reg_go    = (r_op == OP_REGISTER) && r_present && !r_registered && !r_memerr;
    assign o_stat.scan_hit  = |w_word;
    assign o_stat.scan_last = (r_cnt == CW'(G));

    assign w_rd_addr  = PW'(i_slot_index);
    assign w_idx      = PW'(r_slot_idx);
    assign w_in_range = (32'(r_slot_idx) < SLOTS);
    assign w_idx_used = w_in_range && r_used[w_idx];

    // owner memory: one write port (claim), one registered read port (input transfer)
    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            r_owner_mem[w_claim_idx] <= r_owner_in;
        end
        if (i_cmd.load_in) begin
            r_rd_data <= r_owner_mem[w_rd_addr];
        end
    end

    // control state: used map and next-fit pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_ptr  <= '0;
        end else begin
            if (i_cmd.claim) begin
                r_used[w_claim_idx] <= 1'b1;
                r_ptr               <= w_next_ptr;
            end
            if (i_cmd.finish_read && (r_op == OP_RELEASE) && w_idx_used) begin
                r_used[w_idx] <= 1'b0;
            end
        end
    end

    // payload: latched item, scan position, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op         <= i_operation;
            r_present    <= i_object_present;
            r_registered <= i_object_registered;
            r_memerr     <= i_object_memory_error;
            r_owner_in   <= i_owner_in;
            r_slot_idx   <= i_slot_index;
        end
        if (i_cmd.scan_init) begin
            r_grp   <= GW'(AW'(r_ptr) >> OW);
            r_ofs   <= OW'(AW'(r_ptr));
            r_first <= 1'b1;
            r_cnt   <= '0;
        end
        if (i_cmd.scan_step) begin
            r_grp   <= (r_grp == GW'(G - 1)) ? '0 : r_grp + 1'b1;
            r_first <= 1'b0;
            r_cnt   <= r_cnt + 1'b1;
        end
        if (i_cmd.claim) begin
            r_status    <= ST_OK;
            r_slot_out  <= SLOT_OUT_W'(w_claim_idx);
            r_owner_out <= r_owner_in;
            r_was_used  <= 1'b0;
        end
        if (i_cmd.finish_full) begin
            r_status    <= ST_FULL;
            r_slot_out  <= '0;
            r_owner_out <= '0;
            r_was_used  <= 1'b0;
        end
        if (i_cmd.finish_read) begin
            case (r_op)
                OP_REGISTER: begin
                    if (!r_present) begin
                        r_status <= ST_NO_OBJECT;
                    end else if (r_registered) begin
                        r_status <= ST_ALREADY;
                    end else begin
                        r_status <= ST_MEM_ERROR;
                    end
                    r_slot_out  <= '0;
                    r_owner_out <= '0;
                    r_was_used  <= 1'b0;
                end
                OP_RELEASE: begin
                    // a free slot always reports the empty owner
                    r_status    <= w_idx_used ? ST_OK : ST_BAD_SLOT;
                    r_slot_out  <= SLOT_OUT_W'(r_slot_idx);
                    r_owner_out <= w_idx_used ? r_rd_data : OWNER_NONE;
                    r_was_used  <= w_idx_used;
                end
                OP_LOOKUP: begin
                    r_status    <= w_in_range ? ST_OK : ST_BAD_SLOT;
                    r_slot_out  <= SLOT_OUT_W'(r_slot_idx);
                    r_owner_out <= w_idx_used ? r_rd_data : OWNER_NONE;
                    r_was_used  <= w_idx_used;
                end
                default: begin
                    r_status    <= ST_BAD_SLOT;
                    r_slot_out  <= '0;
                    r_owner_out <= '0;
                    r_was_used  <= 1'b0;
                end
            endcase
        end
    end

    assign o_status        = r_status;
    assign o_slot_out      = r_slot_out;
    assign o_owner_out     = r_owner_out;
    assign o_slot_was_used = r_was_used;

    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |-> !r_used[w_claim_idx])
        else $error("claimed slot already used");

    a_claim_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |=> r_used[$past(w_claim_idx)] && (r_ptr == $past(w_next_ptr)))
        else $error("claim did not mark slot or move pointer");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish_read && (r_op == OP_RELEASE) && w_idx_used) |=> !r_used[$past(w_idx)])
        else $error("release left slot marked used");

endmodule

FILE: hdl/next_fit_slot_allocator_unit.sv
// Next-fit slot allocator.
// Input stream (s_axis): one request per transfer. tuser carries the operation
// (register, release, lookup); tdata carries the object flags, the owner id and
// the slot index. Output stream (m_axis): exactly one result per request, in
// request order: status, slot, owner id and the slot's previous used mark.
// Register searches the used map forward from a rotating next-fit pointer,
// one 16-slot word per cycle, wrapping once; the first word is masked below
// the pointer and visited again unmasked at the end.
// Release, lookup, refused register and undefined operations go from the
// read state straight to the result; a register first scans the used map.
// One request is in flight at a time: s_axis_tready is high only while the
// unit is idle, so a new request is taken only after the previous result
// is transferred.
// When the receiver stalls, the result stays in the output register and no new
// request is taken until it is transferred.
// Reset (synchronous, active low) clears the used map and the pointer; the
// owner memory is not cleared, since a free slot always reports the empty
// owner id. No clearing pass follows reset.
module next_fit_slot_allocator_unit
    import nfsa_pkg::*;
#(
    parameter int SLOTS = NFSA_SLOTS
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] object_present, [1] object_registered, [2] object_memory_error,
    // [34:3] owner_in, [43:35] slot_index, [47:44] zero
    input  logic [47:0] i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  i_s_axis_tuser,
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [2:0] status, [10:3] slot_out, [42:11] owner_out, [43] slot_was_used,
    // [47:44] zero
    output logic [47:0] o_m_axis_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    logic [2:0]            w_status;
    logic [SLOT_OUT_W-1:0] w_slot_out;
    logic [OWNER_W-1:0]    w_owner_out;
    logic                  w_was_used;

    nfsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    nfsa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_operation           (i_s_axis_tuser),
        .i_object_present      (i_s_axis_tdata[0]),
        .i_object_registered   (i_s_axis_tdata[1]),
        .i_object_memory_error (i_s_axis_tdata[2]),
        .i_owner_in            (i_s_axis_tdata[34:3]),
        .i_slot_index          (i_s_axis_tdata[43:35]),
        .o_status              (w_status),
        .o_slot_out            (w_slot_out),
        .o_owner_out           (w_owner_out),
        .o_slot_was_used       (w_was_used)
    );

    assign o_m_axis_tdata = {4'b0000, w_was_used, w_owner_out, w_slot_out, w_status};

endmodule
